FILE: src/srrip_pkg.sv
`default_nettype none

package srrip_pkg;

  // Field widths fixed by the request format
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int PC_W     = 64;
  localparam int SIG_W    = 14;
  localparam int CTR_W    = 3;

  // Signature counter table: one counter per 14-bit signature
  localparam int CTR_ENTRIES = 16384;

  // Defaults for the top-level parameters
  localparam int DEF_SETS = 2048;
  localparam int DEF_WAYS = 16;

  // Signature hash modulus; 2^14 is congruent to 3 modulo it
  localparam logic [SIG_W-1:0] SIG_MOD = 14'd16381;

  localparam logic [CTR_W-1:0] CTR_MAX      = 3'd7;
  localparam logic [CTR_W-1:0] CTR_DEAD_MAX = 3'd1;
  localparam logic [1:0]       RRPV_DISTANT = 2'd3;
  localparam logic [1:0]       RRPV_LONG    = 2'd2;
  localparam logic [1:0]       RRPV_NEAR    = 2'd0;

  // Request opcodes
  localparam logic [1:0] OP_VICTIM = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_ACCESS = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way;
    logic [PC_W-1:0]     pc;
    logic                hit;
  } req_t;

  typedef struct packed {
    logic [WAY_IN_W-1:0] victim_way;
    logic                predicted_dead;
  } rsp_t;

  // Per-block replacement state
  typedef struct packed {
    logic [SIG_W-1:0] sig;
    logic             reused;
    logic [1:0]       rrpv;
  } blk_t;

  localparam blk_t BLK_INIT = '{sig: '0, reused: 1'b0, rrpv: RRPV_DISTANT};

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_ROW_RD,
    ST_SCAN,
    ST_CTR_OLD,
    ST_CTR_UPD,
    ST_CTR_NEW,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

FILE: src/srrip_hash.sv
`default_nettype none

// PC signature hash: s = pc >> 2, x = s ^ s>>4 ^ s>>8, sig = x mod 16381.
// The modulo folds the high part back in, x = lo14 + 3*hi, one fold per
// cycle, until the high part is zero; a last compare and subtract finishes.
module srrip_hash (
  input  wire logic                             clk,
  input  wire logic                             load,
  input  wire logic [srrip_pkg::PC_W-1:0]       pc,
  output logic                                  ready,
  output logic      [srrip_pkg::SIG_W-1:0]      sig
);

  localparam int X_W  = srrip_pkg::PC_W - 2;
  localparam int HI_W = X_W - srrip_pkg::SIG_W;

  logic [X_W-1:0]              s;
  logic [X_W-1:0]              x;
  logic [X_W-1:0]              x_next;
  logic [HI_W-1:0]             hi;
  logic [srrip_pkg::SIG_W-1:0] lo;

  assign s  = pc[srrip_pkg::PC_W-1:2];
  assign hi = x[X_W-1:srrip_pkg::SIG_W];
  assign lo = x[srrip_pkg::SIG_W-1:0];

  // One fold per cycle; idempotent once the high part is gone
  assign x_next = X_W'(lo) + X_W'(hi) + (X_W'(hi) << 1);

  always_ff @(posedge clk) begin
    if (load) begin
      x <= s ^ (s >> 4) ^ (s >> 8);
    end else begin
      x <= x_next;
    end
  end

  assign ready = (hi == '0);
  assign sig   = (lo >= srrip_pkg::SIG_MOD) ? (lo - srrip_pkg::SIG_MOD) : lo;

endmodule

`default_nettype wire

FILE: src/signature_rrip_replacement.sv
`default_nettype none

// SHiP-style replacement state on 2-bit RRIP for a SETS x WAYS cache. A request
// beat is taken when start is high and busy is low; its one result is shown on
// rsp for a single cycle with done high and must be captured then, as there is
// no way to hold it. After reset the block clears the per-set row memory and
// the signature counter memory, with busy high, until both are cleared. Each
// request then goes through preparation: the set remainder modulo SETS comes
// from a reciprocal multiply at accept, then a multiply back and subtract,
// while the PC hash needs up to five folds, one per cycle, depending on the
// PC. It then reads the set's row and continues per op: a victim search scans
// one way per cycle and writes the aged row back, a fill reads the evicted
// block's counter, decrements it if the block was never reused and reads the
// new signature's counter on the counter memory port, a hit reads and
// increments the block's counter. A final state writes the row. Requests that
// change nothing (miss update, way out of range, unknown op) go from accept
// straight to that final state. The next request may be taken in the done
// cycle.
module signature_rrip_replacement #(
  parameter int SETS = srrip_pkg::DEF_SETS,
  parameter int WAYS = srrip_pkg::DEF_WAYS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire srrip_pkg::req_t   req,
  output logic                   busy,
  output logic                   done,
  output srrip_pkg::rsp_t        rsp
);

  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CLR_LEN = (SETS > srrip_pkg::CTR_ENTRIES) ? SETS : srrip_pkg::CTR_ENTRIES;
  localparam int CLR_W   = $clog2(CLR_LEN);

  // ceil(2^22 / SETS): exact quotient for every 11-bit set_index
  localparam int RCP_SH = 22;
  localparam int PROD_W = srrip_pkg::SET_IN_W + RCP_SH + 1;
  localparam logic [RCP_SH:0] SET_RCP =
    (RCP_SH+1)'(((64'd1 << RCP_SH) + 64'(SETS) - 64'd1) / 64'(SETS));

  srrip_pkg::state_t state;
  srrip_pkg::state_t state_next;

  // Latched request
  logic [1:0]                     op_r;
  logic [srrip_pkg::SET_IN_W-1:0] set_in_r;
  logic [WAY_W-1:0]               way_r;
  logic                           nop;

  // Set remainder unit
  logic [srrip_pkg::SET_IN_W-1:0] quot;
  logic                           set_left;
  logic [PROD_W-1:0]              set_prod;
  logic [SET_W-1:0]               rem;
  logic [SET_W-1:0]               rem_next;

  // Victim scan
  logic [WAY_W-1:0] scan_cnt;
  logic [1:0]       top;
  logic [WAY_W-1:0] first;
  logic [1:0]       scan_rrpv;
  logic [1:0]       age;

  logic [CLR_W-1:0] clr_cnt;

  // Memories
  srrip_pkg::blk_t [WAYS-1:0] row_mem [SETS];
  srrip_pkg::blk_t [WAYS-1:0] row_q;
  srrip_pkg::blk_t [WAYS-1:0] row_wdata;
  logic [SET_W-1:0]           row_addr;
  logic                       row_we;
  logic                       row_re;

  logic [srrip_pkg::CTR_W-1:0] ctr_mem [srrip_pkg::CTR_ENTRIES];
  logic [srrip_pkg::CTR_W-1:0] ctr_q;
  logic [srrip_pkg::CTR_W-1:0] ctr_wdata;
  logic [srrip_pkg::SIG_W-1:0] ctr_addr;
  logic                        ctr_we;
  logic                        ctr_re;

  logic                        accept;
  logic                        way_ok;
  logic                        hash_ready;
  logic [srrip_pkg::SIG_W-1:0] sig;
  logic                        dead;
  srrip_pkg::blk_t             cur_blk;

  assign busy   = (state != srrip_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign way_ok = (32'(req.way) < WAYS);

  srrip_hash u_hash (
    .clk   (clk),
    .load  (accept),
    .pc    (req.pc),
    .ready (hash_ready),
    .sig   (sig)
  );

  // Set remainder: quotient by reciprocal multiply, then multiply back
  assign set_prod = PROD_W'(req.set_index) * PROD_W'(SET_RCP);
  assign rem_next = SET_W'(32'(set_in_r) - 32'(quot) * 32'(SETS));

  assign cur_blk   = row_q[way_r];
  assign scan_rrpv = row_q[scan_cnt].rrpv;
  assign age       = srrip_pkg::RRPV_DISTANT - top;
  assign dead      = (ctr_q <= srrip_pkg::CTR_DEAD_MAX);

  // Sequencer: next state, memory ports and row write data
  always_comb begin
    state_next = state;
    row_addr   = rem;
    row_we     = 1'b0;
    row_re     = 1'b0;
    row_wdata  = row_q;
    ctr_addr   = cur_blk.sig;
    ctr_we     = 1'b0;
    ctr_re     = 1'b0;
    ctr_wdata  = '0;
    unique case (state)
      srrip_pkg::ST_CLEAR: begin
        row_addr  = clr_cnt[SET_W-1:0];
        row_we    = (32'(clr_cnt) < SETS);
        row_wdata = {WAYS{srrip_pkg::BLK_INIT}};
        ctr_addr  = clr_cnt[srrip_pkg::SIG_W-1:0];
        ctr_we    = (32'(clr_cnt) < srrip_pkg::CTR_ENTRIES);
        if (32'(clr_cnt) == CLR_LEN - 1) begin
          state_next = srrip_pkg::ST_IDLE;
        end
      end
      srrip_pkg::ST_IDLE: begin
        if (start) begin
          if (req.op == srrip_pkg::OP_VICTIM ||
              (req.op == srrip_pkg::OP_FILL && way_ok) ||
              (req.op == srrip_pkg::OP_ACCESS && way_ok && req.hit)) begin
            state_next = srrip_pkg::ST_PREP;
          end else begin
            state_next = srrip_pkg::ST_FINISH;
          end
        end
      end
      srrip_pkg::ST_PREP: begin
        if (!set_left && hash_ready) begin
          state_next = srrip_pkg::ST_ROW_RD;
        end
      end
      srrip_pkg::ST_ROW_RD: begin
        row_re = 1'b1;
        if (op_r == srrip_pkg::OP_VICTIM) begin
          state_next = srrip_pkg::ST_SCAN;
        end else begin
          state_next = srrip_pkg::ST_CTR_OLD;
        end
      end
      srrip_pkg::ST_SCAN: begin
        if (32'(scan_cnt) == WAYS - 1) begin
          state_next = srrip_pkg::ST_FINISH;
        end
      end
      srrip_pkg::ST_CTR_OLD: begin
        ctr_re     = 1'b1;
        state_next = srrip_pkg::ST_CTR_UPD;
      end
      srrip_pkg::ST_CTR_UPD: begin
        if (op_r == srrip_pkg::OP_FILL) begin
          // Evicted block never reused: weaken its signature
          ctr_we     = !cur_blk.reused && (ctr_q != '0);
          ctr_wdata  = ctr_q - 1'b1;
          state_next = srrip_pkg::ST_CTR_NEW;
        end else begin
          // Hit: strengthen the block's signature
          ctr_we     = (ctr_q != srrip_pkg::CTR_MAX);
          ctr_wdata  = ctr_q + 1'b1;
          state_next = srrip_pkg::ST_FINISH;
        end
      end
      srrip_pkg::ST_CTR_NEW: begin
        ctr_addr   = sig;
        ctr_re     = 1'b1;
        state_next = srrip_pkg::ST_FINISH;
      end
      srrip_pkg::ST_FINISH: begin
        row_we = !nop;
        if (op_r == srrip_pkg::OP_VICTIM) begin
          for (int w = 0; w < WAYS; w++) begin
            row_wdata[w].rrpv = row_q[w].rrpv + age;
          end
        end else if (op_r == srrip_pkg::OP_FILL) begin
          row_wdata[way_r] = '{sig: sig, reused: 1'b0,
                               rrpv: dead ? srrip_pkg::RRPV_DISTANT : srrip_pkg::RRPV_LONG};
        end else begin
          row_wdata[way_r].reused = 1'b1;
          row_wdata[way_r].rrpv   = srrip_pkg::RRPV_NEAR;
        end
        state_next = srrip_pkg::ST_IDLE;
      end
      default: begin
        state_next = srrip_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srrip_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == srrip_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Request latch and set remainder
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= req.op;
      set_in_r <= req.set_index;
      way_r    <= WAY_W'(req.way);
      nop      <= (state_next == srrip_pkg::ST_FINISH);
      quot     <= set_prod[RCP_SH +: srrip_pkg::SET_IN_W];
      set_left <= 1'b1;
    end else if (state == srrip_pkg::ST_PREP && set_left) begin
      rem      <= rem_next;
      set_left <= 1'b0;
    end
  end

  // Victim scan: first way holding the largest RRPV
  always_ff @(posedge clk) begin
    if (state == srrip_pkg::ST_ROW_RD) begin
      scan_cnt <= '0;
      top      <= '0;
      first    <= '0;
    end else if (state == srrip_pkg::ST_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
      if (scan_rrpv > top) begin
        top   <= scan_rrpv;
        first <= scan_cnt;
      end
    end
  end

  // Row memory
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_addr] <= row_wdata;
    end
    if (row_re) begin
      row_q <= row_mem[row_addr];
    end
  end

  // Signature counter memory
  always_ff @(posedge clk) begin
    if (ctr_we) begin
      ctr_mem[ctr_addr] <= ctr_wdata;
    end
    if (ctr_re) begin
      ctr_q <= ctr_mem[ctr_addr];
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == srrip_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == srrip_pkg::ST_FINISH) begin
      rsp.victim_way     <= (!nop && op_r == srrip_pkg::OP_VICTIM) ?
                            srrip_pkg::WAY_IN_W'(first) : '0;
      rsp.predicted_dead <= !nop && op_r == srrip_pkg::OP_FILL && dead;
    end
  end

  // Checks
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_victim_only_op0: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.victim_way != '0) |-> (op_r == srrip_pkg::OP_VICTIM))
    else $error("nonzero victim way on a non-victim request");

  a_dead_only_fill: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.predicted_dead) |-> (op_r == srrip_pkg::OP_FILL))
    else $error("predicted_dead on a non-fill request");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == srrip_pkg::ST_SCAN) |-> (32'(scan_cnt) < WAYS))
    else $error("victim scan ran past the last way");

endmodule

`default_nettype wire

FILE: tb/signature_rrip_replacement_tb.sv
`default_nettype none

module signature_rrip_replacement_tb;

  localparam int SETS = srrip_pkg::DEF_SETS;
  localparam int WAYS = srrip_pkg::DEF_WAYS;
  localparam int BLOCKS = SETS * WAYS;
  localparam int IDLE_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    srrip_pkg::req_t req;
    srrip_pkg::rsp_t rsp;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  srrip_pkg::req_t req = '0;
  logic busy;
  logic done;
  srrip_pkg::rsp_t rsp;

  // Shadow replacement state
  logic [srrip_pkg::CTR_W-1:0] sig_ctr [srrip_pkg::CTR_ENTRIES];
  logic [srrip_pkg::SIG_W-1:0] blk_sig [BLOCKS];
  logic                        blk_reused [BLOCKS];
  logic [1:0]                  blk_rrpv [BLOCKS];

  pending_t expected_rsp_q[$];

  int errors = 0;
  int idle_cycles = 0;
  bit idle_burst = 1'b0;
  int n_victim = 0;
  int n_aged = 0;
  int n_fill_dead = 0;
  int n_fill_live = 0;
  int n_hit = 0;
  int n_ignored = 0;
  int n_checked = 0;

  signature_rrip_replacement #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic srrip_pkg::req_t make_req(logic [1:0] op,
                                               logic [srrip_pkg::SET_IN_W-1:0] set_index,
                                               logic [srrip_pkg::WAY_IN_W-1:0] way,
                                               logic [srrip_pkg::PC_W-1:0] pc,
                                               logic hit);
    srrip_pkg::req_t r;
    r.op = op;
    r.set_index = set_index;
    r.way = way;
    r.pc = pc;
    r.hit = hit;
    return r;
  endfunction

  function automatic int effective_count();
    return n_victim + n_fill_dead + n_fill_live + n_hit;
  endfunction

  // PC fold: drop byte offset, xor in two nibble shifts, reduce mod 16381
  function automatic logic [srrip_pkg::SIG_W-1:0] pc_signature(
      logic [srrip_pkg::PC_W-1:0] pc);
    logic [63:0] s;
    logic [63:0] folded;
    s = pc >> 2;
    folded = (s ^ (s >> 4) ^ (s >> 8)) % 64'(srrip_pkg::SIG_MOD);
    return folded[srrip_pkg::SIG_W-1:0];
  endfunction

  function automatic int pick_gap();
    int roll;
    if (idle_burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Apply one request to the shadow state and work out its result
  task automatic ship_predict(input srrip_pkg::req_t r, output srrip_pkg::rsp_t e);
    int base;
    int idx;
    int top;
    int age;
    int v;
    int w;
    bit found;
    logic [srrip_pkg::SIG_W-1:0] old_sig;
    logic [srrip_pkg::SIG_W-1:0] new_sig;
    e = '0;
    base = (int'(r.set_index) % SETS) * WAYS;
    idx = base + int'(r.way);
    if (r.op == srrip_pkg::OP_VICTIM) begin
      n_victim++;
      top = 0;
      found = 1'b0;
      for (w = 0; w < WAYS && !found; w++) begin
        if (blk_rrpv[base + w] >= srrip_pkg::RRPV_DISTANT) begin
          e.victim_way = w[srrip_pkg::WAY_IN_W-1:0];
          found = 1'b1;
        end else if (int'(blk_rrpv[base + w]) > top) begin
          top = int'(blk_rrpv[base + w]);
        end
      end
      // no distant block: age the whole set until the oldest reaches 3
      if (!found) begin
        n_aged++;
        age = int'(srrip_pkg::RRPV_DISTANT) - top;
        for (w = 0; w < WAYS; w++) begin
          v = int'(blk_rrpv[base + w]) + age;
          if (v > int'(srrip_pkg::RRPV_DISTANT)) v = int'(srrip_pkg::RRPV_DISTANT);
          blk_rrpv[base + w] = v[1:0];
          if (!found && v == int'(srrip_pkg::RRPV_DISTANT)) begin
            e.victim_way = w[srrip_pkg::WAY_IN_W-1:0];
            found = 1'b1;
          end
        end
      end
    end else if (r.op == srrip_pkg::OP_FILL && int'(r.way) < WAYS) begin
      old_sig = blk_sig[idx];
      if (!blk_reused[idx] && sig_ctr[old_sig] != '0)
        sig_ctr[old_sig] = sig_ctr[old_sig] - 1'b1;
      new_sig = pc_signature(r.pc);
      blk_sig[idx] = new_sig;
      blk_reused[idx] = 1'b0;
      if (sig_ctr[new_sig] <= srrip_pkg::CTR_DEAD_MAX) begin
        blk_rrpv[idx] = srrip_pkg::RRPV_DISTANT;
        e.predicted_dead = 1'b1;
        n_fill_dead++;
      end else begin
        blk_rrpv[idx] = srrip_pkg::RRPV_LONG;
        n_fill_live++;
      end
    end else if (r.op == srrip_pkg::OP_ACCESS && int'(r.way) < WAYS && r.hit) begin
      n_hit++;
      old_sig = blk_sig[idx];
      blk_reused[idx] = 1'b1;
      blk_rrpv[idx] = srrip_pkg::RRPV_NEAR;
      if (sig_ctr[old_sig] < srrip_pkg::CTR_MAX)
        sig_ctr[old_sig] = sig_ctr[old_sig] + 1'b1;
    end else begin
      n_ignored++;
    end
  endtask

  // Drive one beat, wait for it to be taken, then idle for a random gap, which may be zero
  task automatic send_req(input srrip_pkg::req_t r, output srrip_pkg::rsp_t e);
    pending_t p;
    int gap;
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    ship_predict(r, e);
    p.req = r;
    p.rsp = e;
    expected_rsp_q.push_back(p);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result check: the receiver cannot stall, so every done beat is taken
  always @(posedge clk) begin
    pending_t p;
    if (!rst && done === 1'b1) begin
      if (expected_rsp_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: victim_way=%0d predicted_dead=%0b",
                   rsp.victim_way, rsp.predicted_dead);
      end else begin
        p = expected_rsp_q.pop_front();
        n_checked++;
        if (rsp.victim_way !== p.rsp.victim_way ||
            rsp.predicted_dead !== p.rsp.predicted_dead) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch op=%0d set=%0d way=%0d pc=%h: ",
                      "exp victim=%0d dead=%0b, got victim=%0d dead=%0b"},
                     p.req.op, p.req.set_index, p.req.way, p.req.pc,
                     p.rsp.victim_way, p.rsp.predicted_dead,
                     rsp.victim_way, rsp.predicted_dead);
        end
      end
    end
  end

  // Watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("signature_rrip_replacement_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic run_reset();
    int i;
    for (i = 0; i < srrip_pkg::CTR_ENTRIES; i++) sig_ctr[i] = '0;
    for (i = 0; i < BLOCKS; i++) begin
      blk_sig[i] = '0;
      blk_reused[i] = 1'b0;
      blk_rrpv[i] = srrip_pkg::RRPV_DISTANT;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  endtask

  // Extremes, every op, saturation both ways, unknown op, miss update
  task automatic test_directed();
    logic [srrip_pkg::PC_W-1:0] pc_a;
    srrip_pkg::rsp_t e;
    int i;
    pc_a = 64'h0000_0000_0040_1234;
    send_req(make_req(OP_UNUSED, 11'd5, 4'd15, '1, 1'b1), e);
    send_req(make_req(srrip_pkg::OP_VICTIM, 11'd0, 4'd0, '0, 1'b0), e);
    send_req(make_req(srrip_pkg::OP_FILL, 11'd0, 4'd0, pc_a, 1'b0), e);
    // train the signature up past saturation
    for (i = 0; i < 8; i++)
      send_req(make_req(srrip_pkg::OP_ACCESS, 11'd0, 4'd0, '0, 1'b1), e);
    send_req(make_req(srrip_pkg::OP_ACCESS, 11'd0, 4'd1, '1, 1'b0), e);
    send_req(make_req(srrip_pkg::OP_FILL, 11'd2047, 4'd15, pc_a, 1'b1), e);
    send_req(make_req(srrip_pkg::OP_VICTIM, 11'd0, 4'd15, '1, 1'b1), e);
    send_req(make_req(srrip_pkg::OP_FILL, 11'd0, 4'd0, '0, 1'b0), e);
    // evicting the never-reused block decrements its signature
    send_req(make_req(srrip_pkg::OP_FILL, 11'd2047, 4'd15, '1, 1'b0), e);
    send_req(make_req(srrip_pkg::OP_FILL, 11'd2047, 4'd15, pc_a, 1'b0), e);
    send_req(make_req(srrip_pkg::OP_VICTIM, 11'd2047, 4'd0, '0, 1'b0), e);
    send_req(make_req(OP_UNUSED, 11'd2047, 4'd0, '0, 1'b0), e);
  endtask

  // Victim search, fill of that victim, reuse by hot PCs, on a few sets
  task automatic test_reuse_training(input int target);
    logic [srrip_pkg::SET_IN_W-1:0] sets [6];
    logic [srrip_pkg::PC_W-1:0] pcs [8];
    int hot [8];
    srrip_pkg::rsp_t e;
    logic [srrip_pkg::SET_IN_W-1:0] s;
    logic [srrip_pkg::WAY_IN_W-1:0] v;
    int p;
    int n;
    int i;
    for (i = 0; i < 6; i++) sets[i] = srrip_pkg::SET_IN_W'($urandom_range(0, SETS - 1));
    for (i = 0; i < 8; i++) begin
      pcs[i] = {$urandom, $urandom};
      hot[i] = $urandom_range(0, 2);
    end
    while (effective_count() < target) begin
      idle_burst = ($urandom_range(0, 9) == 0);
      s = sets[$urandom_range(0, 5)];
      p = $urandom_range(0, 7);
      send_req(make_req(srrip_pkg::OP_VICTIM, s, srrip_pkg::WAY_IN_W'($urandom),
                        {$urandom, $urandom}, 1'($urandom)), e);
      v = e.victim_way;
      send_req(make_req(srrip_pkg::OP_FILL, s, v, pcs[p], 1'($urandom)), e);
      n = (hot[p] == 2) ? $urandom_range(1, 3) : (hot[p] == 1) ? $urandom_range(0, 1) : 0;
      for (i = 0; i < n; i++)
        send_req(make_req(srrip_pkg::OP_ACCESS, s, v, {$urandom, $urandom}, 1'b1), e);
      // touch a random way of the set, hit or miss
      if ($urandom_range(0, 3) == 0)
        send_req(make_req(srrip_pkg::OP_ACCESS, s, srrip_pkg::WAY_IN_W'($urandom),
                          {$urandom, $urandom}, 1'($urandom)), e);
      // the program moves on: a PC changes its reuse habit
      if ($urandom_range(0, 15) == 0) begin
        pcs[p] = {$urandom, $urandom};
        hot[p] = $urandom_range(0, 2);
      end
    end
  endtask

  // Unstructured requests over the full field ranges, op 3 included
  task automatic test_random_noise(input int target);
    srrip_pkg::rsp_t e;
    while (effective_count() < target) begin
      if ($urandom_range(0, 15) == 0) idle_burst = ~idle_burst;
      send_req(make_req(2'($urandom_range(0, 3)), srrip_pkg::SET_IN_W'($urandom),
                        srrip_pkg::WAY_IN_W'($urandom), {$urandom, $urandom},
                        1'($urandom)), e);
    end
  endtask

  initial begin
    run_reset();
    test_directed();
    test_reuse_training(1080);
    idle_burst = 1'b0;
    test_random_noise(1220);
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results: %0d victim searches (%0d aged the set), %0d fills",
             n_checked, n_victim, n_aged, n_fill_dead + n_fill_live);
    $display("fills predicted dead %0d, live %0d; hits %0d; no-op requests %0d",
             n_fill_dead, n_fill_live, n_hit, n_ignored);
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("signature_rrip_replacement_tb: clean");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_rsp_q.size());
      $display("signature_rrip_replacement_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
src/srrip_pkg.sv
src/srrip_hash.sv
src/signature_rrip_replacement.sv
tb/signature_rrip_replacement_tb.sv
